### rtl/cdb_pkg.sv
package cdb_pkg;

  localparam int STORE_DEPTH_DEF   = 1024;
  localparam int ELEMENT_WIDTH_DEF = 32;
  localparam int CNT_W             = 11;
  localparam int VALUE_W           = 32;
  localparam int CMD_W             = 3;
  localparam int IN_TDATA_W        = 40;
  localparam int OUT_TDATA_W       = 80;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(1024);

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_REAR  = 3'd1,
    CMD_DEL_FRONT = 3'd2,
    CMD_DEL_REAR  = 3'd3,
    CMD_PEEK      = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    OP_HOLD      = 2'd0,
    OP_SHIFT_IN  = 2'd1,
    OP_SHIFT_OUT = 2'd2,
    OP_WRITE_AT  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [CNT_W-1:0] count;
  } cell_ctl_t;

endpackage

### rtl/circular_deque_buffer_unit.sv
// double-ended queue of configurable capacity, one command per input beat
// input stream in_*: tdata carries cmd and push_value; every accepted beat
// yields exactly one result beat on out_*, in order
// commands: insert front, insert rear, delete front, delete rear, peek;
// codes 5 to 7 change nothing and report accepted = 0
// the result shows the deque after the command: front and rear element
// (all ones when empty), empty and full flags and occupancy
// storage is two rows of STORE_DEPTH cells, one kept in front-first order
// and one in rear-first order, so both ends sit in a fixed cell; an insert
// shifts one row by one cell and writes the other at the occupancy slot
// the result beat is registered and comes out in the cycle after its input
// beat; one beat per cycle is sustained while out_tready is high, set by the single output register
// when the receiver stalls, the result holds in the output register and
// in_tready drops until it is taken
// cfg_we writes the capacity (0 acts as 1, above STORE_DEPTH acts as
// STORE_DEPTH) and empties the deque; write only while idle
// reset (rst_n low, synchronous) empties the deque, sets capacity to 1024
// and drops out_tvalid; cell contents are not cleared
module circular_deque_buffer_unit #(
  parameter int STORE_DEPTH   = cdb_pkg::STORE_DEPTH_DEF,
  parameter int ELEMENT_WIDTH = cdb_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cdb_pkg::CNT_W-1:0]         cfg_wdata,   // active_capacity
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [2:0] cmd, [34:3] push_value, [39:35] zero
  input  logic [cdb_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] accepted, [32:1] front_value, [64:33] rear_value, [65] is_empty,
  // [66] is_full, [77:67] occupancy, [79:78] zero
  output logic [cdb_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int CNT_W = cdb_pkg::CNT_W;
  localparam int VW    = cdb_pkg::VALUE_W;

  logic [CNT_W-1:0] cap_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r;

  logic             acc_r;
  logic [VW-1:0]    front_r, rear_r;
  logic             empty_r, full_r;
  logic [CNT_W-1:0] occ_r;

  logic [CNT_W-1:0] cap_eff;
  logic             in_fire;
  logic             full_now, empty_now;
  logic             ok;
  logic [cdb_pkg::CMD_W-1:0] cmd;
  logic signed [VW-1:0] push_s;
  logic signed [ELEMENT_WIDTH-1:0] elem;
  logic signed [ELEMENT_WIDTH-1:0] fwd_head, rev_head;
  cdb_pkg::cell_ctl_t fwd_ctl, rev_ctl;

  assign cmd    = in_tdata[cdb_pkg::CMD_W-1:0];
  assign push_s = signed'(in_tdata[cdb_pkg::CMD_W +: VW]);
  assign elem   = ELEMENT_WIDTH'(push_s);

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(cap_r) > 32'(STORE_DEPTH)) begin
      cap_eff = CNT_W'(STORE_DEPTH);
    end else begin
      cap_eff = cap_r;
    end
  end

  assign full_now  = (cnt_r >= cap_eff);
  assign empty_now = (cnt_r == '0);
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // command decode: fwd row holds front at cell 0, rev row holds rear at cell 0
  always_comb begin
    ok            = 1'b0;
    cnt_nxt       = cnt_r;
    fwd_ctl.op    = cdb_pkg::OP_HOLD;
    fwd_ctl.count = cnt_r;
    rev_ctl.op    = cdb_pkg::OP_HOLD;
    rev_ctl.count = cnt_r;
    unique case (cmd)
      cdb_pkg::CMD_INS_FRONT: begin
        ok = !full_now;
        if (ok) begin
          fwd_ctl.op = cdb_pkg::OP_SHIFT_IN;
          rev_ctl.op = cdb_pkg::OP_WRITE_AT;
          cnt_nxt    = cnt_r + CNT_W'(1);
        end
      end
      cdb_pkg::CMD_INS_REAR: begin
        ok = !full_now;
        if (ok) begin
          fwd_ctl.op = cdb_pkg::OP_WRITE_AT;
          rev_ctl.op = cdb_pkg::OP_SHIFT_IN;
          cnt_nxt    = cnt_r + CNT_W'(1);
        end
      end
      cdb_pkg::CMD_DEL_FRONT: begin
        ok = !empty_now;
        if (ok) begin
          fwd_ctl.op = cdb_pkg::OP_SHIFT_OUT;
          cnt_nxt    = cnt_r - CNT_W'(1);
        end
      end
      cdb_pkg::CMD_DEL_REAR: begin
        ok = !empty_now;
        if (ok) begin
          rev_ctl.op = cdb_pkg::OP_SHIFT_OUT;
          cnt_nxt    = cnt_r - CNT_W'(1);
        end
      end
      cdb_pkg::CMD_PEEK: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    if (!in_fire) begin
      fwd_ctl.op = cdb_pkg::OP_HOLD;
      rev_ctl.op = cdb_pkg::OP_HOLD;
      cnt_nxt    = cnt_r;
    end
  end

  cdb_chain #(
    .DEPTH (STORE_DEPTH),
    .W     (ELEMENT_WIDTH)
  ) u_fwd (
    .clk      (clk),
    .ctl      (fwd_ctl),
    .in_data  (elem),
    .head_nxt (fwd_head)
  );

  cdb_chain #(
    .DEPTH (STORE_DEPTH),
    .W     (ELEMENT_WIDTH)
  ) u_rev (
    .clk      (clk),
    .ctl      (rev_ctl),
    .in_data  (elem),
    .head_nxt (rev_head)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= cdb_pkg::CAP_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      acc_r   <= ok;
      empty_r <= (cnt_nxt == '0);
      full_r  <= (cnt_nxt >= cap_eff);
      occ_r   <= cnt_nxt;
      if (cnt_nxt == '0) begin
        front_r <= '1;
        rear_r  <= '1;
      end else begin
        front_r <= VW'(fwd_head);
        rear_r  <= VW'(rev_head);
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, occ_r, full_r, empty_r, rear_r, front_r, acc_r};

`ifndef NO_ASSERTIONS
  a_cnt_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cap_eff)
    else $error("occupancy above capacity");

  a_ins_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !cfg_we && ok &&
     (cmd == cdb_pkg::CMD_INS_FRONT || cmd == cdb_pkg::CMD_INS_REAR))
    |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("insert did not raise occupancy");

  a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !ok &&
     (cmd == cdb_pkg::CMD_INS_FRONT || cmd == cdb_pkg::CMD_INS_REAR))
    |-> full_now)
    else $error("insert refused while not full");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && empty_r) |-> (occ_r == '0 && front_r == '1 && rear_r == '1))
    else $error("empty result carries data");
`endif

endmodule

### rtl/cdb_cell.sv
module cdb_cell #(
  parameter int W   = cdb_pkg::ELEMENT_WIDTH_DEF,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cdb_pkg::cell_ctl_t ctl,
  input  logic [W-1:0]      in_data,
  input  logic [W-1:0]      left_q,
  input  logic [W-1:0]      right_q,
  output logic [W-1:0]      q,
  output logic [W-1:0]      q_nxt
);

  localparam bit IDX_REACHABLE = (IDX < (1 << cdb_pkg::CNT_W));

  logic [W-1:0] q_r;
  logic         hit;

  assign hit = IDX_REACHABLE && (ctl.count == cdb_pkg::CNT_W'(IDX));

  always_comb begin
    q_nxt = q_r;
    unique case (ctl.op)
      cdb_pkg::OP_HOLD:      q_nxt = q_r;
      cdb_pkg::OP_SHIFT_IN:  q_nxt = left_q;
      cdb_pkg::OP_SHIFT_OUT: q_nxt = right_q;
      cdb_pkg::OP_WRITE_AT:  q_nxt = hit ? in_data : q_r;
      default:               q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

### rtl/cdb_chain.sv
module cdb_chain #(
  parameter int DEPTH = cdb_pkg::STORE_DEPTH_DEF,
  parameter int W     = cdb_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic               clk,
  input  cdb_pkg::cell_ctl_t ctl,
  input  logic [W-1:0]       in_data,
  output logic [W-1:0]       head_nxt
);

  logic [W-1:0] q     [DEPTH];
  logic [W-1:0] q_nxt [DEPTH];

  // cell 0 is the end this chain serves; shift-in enters there
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] left_q;
    logic [W-1:0] right_q;

    if (i == 0) begin : g_first
      assign left_q = in_data;
    end else begin : g_mid
      assign left_q = q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_inner
      assign right_q = q[i+1];
    end

    cdb_cell #(
      .W   (W),
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .in_data (in_data),
      .left_q  (left_q),
      .right_q (right_q),
      .q       (q[i]),
      .q_nxt   (q_nxt[i])
    );
  end

  assign head_nxt = q_nxt[0];

endmodule
